### hw/rtl/stdl_pkg.sv
// shared types and constants for the typed length deframer
`timescale 1ns / 1ps
`default_nettype none

package stdl_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 8;
	localparam int LEN_W  = 9;
	// header length plus header extra, wide enough for the byte clamp too
	localparam int CMP_W  = 2 * BYTE_W + 1;

	localparam int MAX_FRAME_BYTES = 256;
	localparam logic [CMP_W-1:0] MAX_LIMIT = CMP_W'(MAX_FRAME_BYTES);

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h6A;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hA6;
	localparam logic [BYTE_W-1:0] TYPE_MASK   = 8'h7F;
	localparam logic [BYTE_W-1:0] TYPE_MAX    = 8'd3;
	localparam logic [CMP_W-1:0]  HEADER_EXTRA = CMP_W'(8);

	localparam logic [POS_W-1:0] POS_SYNC_A = 8'd0;
	localparam logic [POS_W-1:0] POS_SYNC_B = 8'd1;
	localparam logic [POS_W-1:0] POS_TYPE   = 8'd2;
	localparam logic [LEN_W-1:0] CNT_BODY   = 9'd3;
	localparam logic [LEN_W-1:0] CNT_LEN_HI = 9'd5;
	localparam logic [LEN_W-1:0] CNT_LEN_LO = 9'd6;

	localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RST = 9'd256;

	typedef enum logic [1:0] {
		ST_HUNT = 2'd0,
		ST_BYTE = 2'd1,
		ST_LAST = 2'd2,
		ST_DROP = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [BYTE_W-1:0]  data_byte;
		logic [POS_W-1:0]   position;
		logic [LEN_W-1:0]   frame_length;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/stdl_if.sv
// handshake channels for received words, result words and the limit register
`timescale 1ns / 1ps
`default_nettype none

interface stdl_rx_if;
	logic                      valid;
	logic                      ready;
	logic [stdl_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface stdl_res_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [stdl_pkg::BYTE_W-1:0] data_byte;
	logic [stdl_pkg::POS_W-1:0]  position;
	logic [stdl_pkg::LEN_W-1:0]  frame_length;

	modport source (output valid, output status, output data_byte, output position,
		output frame_length, input ready);
	modport sink (input valid, input status, input data_byte, input position,
		input frame_length, output ready);
endinterface

interface stdl_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [stdl_pkg::LEN_W-1:0] max_frame_len;

	modport source (output valid, output max_frame_len, input ready);
	modport sink (input valid, input max_frame_len, output ready);
endinterface

`default_nettype wire

### hw/rtl/sync_6aa6_typed_length_deframer.sv
// top level: input register, parser, result register and limit register
// path: a word accepted into the input register has its result loaded into the
//   output register once that register is free, which raises res.valid
// throughput: one word per cycle while res.ready allows, set by the header compare
//   and counter update in the parser; ready follows the output register occupancy
// reset: clears both stage valids and all parser state, limit returns to 256
`timescale 1ns / 1ps
`default_nettype none

module sync_6aa6_typed_length_deframer (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stdl_rx_if.sink     rx,
	stdl_res_if.source  res,
	stdl_cfg_if.sink    cfg
);

	logic                        valid_s1;
	logic [stdl_pkg::BYTE_W-1:0] byte_s1;
	logic                        valid_s2;
	stdl_pkg::result_t           result_s2;
	stdl_pkg::result_t           parse_result;
	logic [stdl_pkg::LEN_W-1:0]  max_frame_len_q;
	logic                        out_free;
	logic                        advance;

	assign out_free = !valid_s2 || res.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= stdl_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg.valid && cfg.ready) begin
			max_frame_len_q <= cfg.max_frame_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	stdl_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.rx_byte       (byte_s1),
		.max_frame_len (max_frame_len_q),
		.result        (parse_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= parse_result;
		end
	end

	assign res.valid        = valid_s2;
	assign res.status       = result_s2.status;
	assign res.data_byte    = result_s2.data_byte;
	assign res.position     = result_s2.position;
	assign res.frame_length = result_s2.frame_length;

endmodule

`default_nettype wire

### hw/rtl/stdl_parser.sv
// sync hunt, header decode and frame byte counting for one word per step
`timescale 1ns / 1ps
`default_nettype none

module stdl_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [stdl_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [stdl_pkg::LEN_W-1:0]  max_frame_len,
	output stdl_pkg::result_t                result
);

	logic                        in_frame_q, in_frame_d;
	logic                        prev_first_q, prev_first_d;
	logic                        pair_seen_q, pair_seen_d;
	logic [stdl_pkg::LEN_W-1:0]  byte_count_q, byte_count_d;
	logic [stdl_pkg::BYTE_W-1:0] length_high_q, length_high_d;
	logic [stdl_pkg::LEN_W-1:0]  total_length_q, total_length_d;

	logic [stdl_pkg::CMP_W-1:0]  total_ext;
	logic [stdl_pkg::CMP_W-1:0]  cfg_ext;
	logic [stdl_pkg::CMP_W-1:0]  limit_ext;
	logic [stdl_pkg::LEN_W-1:0]  cnt_inc;
	logic [stdl_pkg::LEN_W-1:0]  tl_eff;
	logic                        at_len_lo;
	logic                        drop;
	logic                        type_ok;

	assign total_ext = stdl_pkg::CMP_W'({length_high_q, rx_byte}) + stdl_pkg::HEADER_EXTRA;
	assign cfg_ext   = stdl_pkg::CMP_W'(max_frame_len);
	assign limit_ext = (cfg_ext > stdl_pkg::MAX_LIMIT) ? stdl_pkg::MAX_LIMIT : cfg_ext;
	assign cnt_inc   = byte_count_q + stdl_pkg::LEN_W'(1);
	assign at_len_lo = (byte_count_q == stdl_pkg::CNT_LEN_LO);
	assign drop      = at_len_lo && (total_ext > limit_ext);
	assign tl_eff    = at_len_lo ? total_ext[stdl_pkg::LEN_W-1:0] : total_length_q;
	assign type_ok   = ((rx_byte & stdl_pkg::TYPE_MASK) <= stdl_pkg::TYPE_MAX);

	always_comb begin
		in_frame_d     = in_frame_q;
		prev_first_d   = prev_first_q;
		pair_seen_d    = pair_seen_q;
		byte_count_d   = byte_count_q;
		length_high_d  = length_high_q;
		total_length_d = total_length_q;

		result.status       = stdl_pkg::ST_HUNT;
		result.data_byte    = rx_byte;
		result.position     = stdl_pkg::POS_SYNC_A;
		result.frame_length = '0;

		if (in_frame_q) begin
			byte_count_d    = cnt_inc;
			result.position = byte_count_q[stdl_pkg::POS_W-1:0];
			if (byte_count_q == stdl_pkg::CNT_LEN_HI) begin
				length_high_d = rx_byte;
			end
			priority if (drop) begin
				in_frame_d     = 1'b0;
				byte_count_d   = '0;
				total_length_d = '0;
				result.status  = stdl_pkg::ST_DROP;
			end else if ((tl_eff != '0) && (cnt_inc == tl_eff)) begin
				in_frame_d          = 1'b0;
				byte_count_d        = '0;
				total_length_d      = '0;
				result.status       = stdl_pkg::ST_LAST;
				result.frame_length = tl_eff;
			end else begin
				total_length_d      = tl_eff;
				result.status       = stdl_pkg::ST_BYTE;
				result.frame_length = tl_eff;
			end
		end else if (pair_seen_q && type_ok) begin
			pair_seen_d     = 1'b0;
			prev_first_d    = 1'b0;
			in_frame_d      = 1'b1;
			byte_count_d    = stdl_pkg::CNT_BODY;
			length_high_d   = '0;
			total_length_d  = '0;
			result.status   = stdl_pkg::ST_BYTE;
			result.position = stdl_pkg::POS_TYPE;
		end else begin
			pair_seen_d = 1'b0;
			priority if (rx_byte == stdl_pkg::SYNC_FIRST) begin
				prev_first_d = 1'b1;
			end else if ((rx_byte == stdl_pkg::SYNC_SECOND) && prev_first_q) begin
				prev_first_d    = 1'b0;
				pair_seen_d     = 1'b1;
				result.position = stdl_pkg::POS_SYNC_B;
			end else begin
				prev_first_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			prev_first_q   <= 1'b0;
			pair_seen_q    <= 1'b0;
			byte_count_q   <= '0;
			length_high_q  <= '0;
			total_length_q <= '0;
		end else if (step) begin
			in_frame_q     <= in_frame_d;
			prev_first_q   <= prev_first_d;
			pair_seen_q    <= pair_seen_d;
			byte_count_q   <= byte_count_d;
			length_high_q  <= length_high_d;
			total_length_q <= total_length_d;
		end
	end

	// counter sits at zero while hunting and past the type byte inside a frame
	a_count_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (byte_count_q == '0))
		else $error("byte counter not cleared while hunting");

	a_count_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (byte_count_q >= stdl_pkg::CNT_BODY))
		else $error("byte counter below body start inside frame");

	a_len_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(total_length_q != '0) |-> in_frame_q)
		else $error("frame length held outside a frame");

	a_pair_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		pair_seen_q |-> !in_frame_q)
		else $error("sync pair flag set inside a frame");

	a_end_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ((result.status == stdl_pkg::ST_LAST) || (result.status == stdl_pkg::ST_DROP)))
		|=> !in_frame_q)
		else $error("frame still open after last or dropped word");

endmodule

`default_nettype wire
